[src/bfbp_pkg.sv]
package bfbp_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam int CMD_W = 4;
  localparam int DATA_W = 64;
  localparam int BYTE_W = 8;
  localparam int SPACE_W = 11;
  localparam int BITCNT_W = 3;
  localparam int ACCUM_W = 7;
  localparam int LAST_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_BYTE = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HALF = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_WORD = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH_DWORD = 4'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH_BIT = 4'd4;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 4'd5;
  localparam logic [CMD_W-1:0] CMD_POP = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 4'd7;

  localparam logic [BITCNT_W-1:0] BITS_FULL = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_FINISH
  } state_t;

  function automatic logic [LAST_W-1:0] last_byte(input logic [CMD_W-1:0] cmd);
    logic [LAST_W-1:0] last;
    case (cmd)
      CMD_PUSH_HALF: last = 3'd1;
      CMD_PUSH_WORD: last = 3'd3;
      CMD_PUSH_DWORD: last = 3'd7;
      default: last = 3'd0;
    endcase
    return last;
  endfunction

endpackage

[src/bfbp_ram.sv]
module bfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/byte_fifo_with_bit_packer.sv]
// Circular byte queue with a bit packer in front. A request is taken when start is high and
// busy is low, and its one result appears for exactly one cycle with done high. A push of
// n bytes (1, 2, 4 or 8) passes the push state, then the finish state, before its result,
// because the bytes leave a shift register one per cycle through the single write port
// of the byte memory; an eighth packed bit or a flush of pending bits does the same. A pop
// of a non-empty queue uses the pop state for the registered read; the rest go straight
// to finish. The receiver cannot stall: a result that is not taken in its cycle is gone.
module byte_fifo_with_bit_packer #(
  parameter int DEPTH = bfbp_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bfbp_pkg::CMD_W-1:0]    cmd,
  input  logic [bfbp_pkg::DATA_W-1:0]   data_value,
  output logic                          busy,
  output logic                          done,
  output logic [bfbp_pkg::BYTE_W-1:0]   pop_data,
  output logic                          pop_valid,
  output logic [bfbp_pkg::SPACE_W-1:0]  space,
  output logic                          not_empty,
  output logic                          overflow,
  output logic [bfbp_pkg::BITCNT_W-1:0] bits_pending
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bfbp_pkg::state_t state, state_next;

  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic [bfbp_pkg::ACCUM_W-1:0] bit_accum;
  logic [bfbp_pkg::BITCNT_W-1:0] bit_count;
  logic [bfbp_pkg::DATA_W-1:0] shreg;
  logic [bfbp_pkg::LAST_W-1:0] remain;
  logic ovf;
  logic pop_hit;

  logic accept;
  logic full;
  logic mem_we;
  logic mem_re;
  logic [bfbp_pkg::BYTE_W-1:0] rd_data;
  logic [31:0] space_wide;
  logic [bfbp_pkg::ACCUM_W-1:0] bit_accum_next;

  assign accept = start && !busy;
  assign busy = (state != bfbp_pkg::ST_IDLE);
  assign full = (count == CW'(DEPTH));
  assign mem_we = (state == bfbp_pkg::ST_PUSH) && !full;
  assign mem_re = (state == bfbp_pkg::ST_POP);
  assign space_wide = 32'(DEPTH) - 32'(count);
  assign bit_accum_next = bit_accum | (bfbp_pkg::ACCUM_W'(data_value[0]) << bit_count);

  bfbp_ram #(
    .WIDTH(bfbp_pkg::BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wptr),
    .wdata(shreg[bfbp_pkg::BYTE_W-1:0]),
    .re   (mem_re),
    .raddr(rptr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bfbp_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd inside {bfbp_pkg::CMD_PUSH_BYTE, bfbp_pkg::CMD_PUSH_HALF,
                          bfbp_pkg::CMD_PUSH_WORD, bfbp_pkg::CMD_PUSH_DWORD}) begin
            state_next = bfbp_pkg::ST_PUSH;
          end else if (cmd == bfbp_pkg::CMD_PUSH_BIT) begin
            state_next = (bit_count == bfbp_pkg::BITS_FULL) ? bfbp_pkg::ST_PUSH
                                                            : bfbp_pkg::ST_FINISH;
          end else if (cmd == bfbp_pkg::CMD_FLUSH) begin
            state_next = (bit_count != '0) ? bfbp_pkg::ST_PUSH : bfbp_pkg::ST_FINISH;
          end else if (cmd == bfbp_pkg::CMD_POP) begin
            state_next = (count != '0) ? bfbp_pkg::ST_POP : bfbp_pkg::ST_FINISH;
          end else begin
            state_next = bfbp_pkg::ST_FINISH;
          end
        end
      end
      bfbp_pkg::ST_PUSH: begin
        if (remain == '0) begin
          state_next = bfbp_pkg::ST_FINISH;
        end
      end
      bfbp_pkg::ST_POP: state_next = bfbp_pkg::ST_FINISH;
      bfbp_pkg::ST_FINISH: state_next = bfbp_pkg::ST_IDLE;
      default: state_next = bfbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      bit_accum <= '0;
      bit_count <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == bfbp_pkg::ST_FINISH);
      if (accept) begin
        if (cmd == bfbp_pkg::CMD_CLEAR) begin
          wptr <= '0;
          rptr <= '0;
          count <= '0;
        end
        if (cmd == bfbp_pkg::CMD_PUSH_BIT) begin
          if (bit_count == bfbp_pkg::BITS_FULL) begin
            bit_accum <= '0;
            bit_count <= '0;
          end else begin
            bit_accum <= bit_accum_next;
            bit_count <= bit_count + 3'd1;
          end
        end
        if (cmd == bfbp_pkg::CMD_FLUSH) begin
          bit_accum <= '0;
          bit_count <= '0;
        end
      end
      if (mem_we) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
        count <= count + CW'(1);
      end
      if (mem_re) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ovf <= 1'b0;
      pop_hit <= 1'b0;
      remain <= bfbp_pkg::last_byte(cmd);
      if (cmd == bfbp_pkg::CMD_PUSH_BIT) begin
        shreg <= bfbp_pkg::DATA_W'({data_value[0], bit_accum});
      end else if (cmd == bfbp_pkg::CMD_FLUSH) begin
        shreg <= bfbp_pkg::DATA_W'(bit_accum);
      end else begin
        shreg <= data_value;
      end
    end
    if (state == bfbp_pkg::ST_PUSH) begin
      shreg <= shreg >> bfbp_pkg::BYTE_W;
      remain <= remain - 3'd1;
      if (full) begin
        ovf <= 1'b1;
      end
    end
    if (mem_re) begin
      pop_hit <= 1'b1;
    end
    if (state == bfbp_pkg::ST_FINISH) begin
      pop_data <= pop_hit ? rd_data : '0;
      pop_valid <= pop_hit;
      space <= space_wide[bfbp_pkg::SPACE_W-1:0];
      not_empty <= (count != '0);
      overflow <= ovf;
      bits_pending <= bit_count;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("Stored byte count exceeds the queue depth.");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == bfbp_pkg::ST_FINISH))
    else $error("A result appeared without a finishing cycle.");

  a_pop_leaves_room: assert property (@(posedge clk) disable iff (rst)
    done && pop_valid |-> !full)
    else $error("The queue is full right after a byte was popped.");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> full)
    else $error("A byte was dropped although the queue had room.");
`endif

endmodule
